// ===== hdl/mme_pkg.sv =====
`default_nettype none

package mme_pkg;

   // Operation carried in the request tuser field.
   typedef enum logic [1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2
   } op_type;

   localparam int OP_W = 2;

   // Configuration register indexes and format.
   localparam int CSR_IDX_W = 2;
   localparam int CFG_W     = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_OF_A  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_OF_B  = 2'd2;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   // Control tag that travels alongside each multiply-accumulate step.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/mme_ram.sv =====
`default_nettype none

module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/mme_seq.sv =====
`default_nettype none

module mme_seq #(
   parameter int IDX_W      = 3,
   parameter int ELEM_WIDTH = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [IDX_W:0]          nr,
   input  wire logic [IDX_W:0]          nk,
   input  wire logic [IDX_W:0]          nc,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [mme_pkg::OP_W-1:0] req_op,
   input  wire logic [IDX_W-1:0]        req_row,
   input  wire logic [IDX_W-1:0]        req_col,
   input  wire logic [ELEM_WIDTH-1:0]   req_elem,
   output logic                         a_we,
   output logic                         b_we,
   output logic [2*IDX_W-1:0]           wr_addr,
   output logic [ELEM_WIDTH-1:0]        wr_data,
   output logic [2*IDX_W-1:0]           a_raddr,
   output logic [2*IDX_W-1:0]           b_raddr,
   output mme_pkg::mac_ctrl_type        issue,
   output logic [IDX_W-1:0]             el_row,
   output logic [IDX_W-1:0]             el_col,
   output logic                         el_last,
   input  wire logic                    xfer
);

   localparam int DIM_W = IDX_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;

   mme_pkg::op_type  op;
   logic             accept;
   logic             i_last, j_last, k_last;

   assign op     = mme_pkg::op_type'(req_op);
   assign accept = req_tvalid && req_tready;

   assign i_last = ({1'b0, i_ff} == nr - DIM_W'(1));
   assign j_last = ({1'b0, j_ff} == nc - DIM_W'(1));
   assign k_last = ({1'b0, k_ff} == nk - DIM_W'(1));

   assign req_tready = (state_ff == ST_IDLE);

   // Loads write straight into the stores; out-of-range loads are dropped.
   always_comb begin
      a_we = 1'b0;
      b_we = 1'b0;
      if (accept) begin
         unique case (op)
            mme_pkg::OP_LOAD_A: a_we = ({1'b0, req_row} < nr) && ({1'b0, req_col} < nk);
            mme_pkg::OP_LOAD_B: b_we = ({1'b0, req_row} < nk) && ({1'b0, req_col} < nc);
            default: ;
         endcase
      end
   end

   assign wr_addr = {req_row, req_col};
   assign wr_data = req_elem;

   assign a_raddr = {i_ff, k_ff};
   assign b_raddr = {k_ff, j_ff};
   // Fields from the top: valid, first, last.
   assign issue   = {(state_ff == ST_RUN), (k_ff == '0), k_last};

   assign el_row  = i_ff;
   assign el_col  = j_ff;
   assign el_last = i_last && j_last;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && op == mme_pkg::OP_COMPUTE) begin
               state_in = ST_RUN;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            if (k_last) begin
               state_in = ST_WAIT;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_WAIT: begin
            if (xfer) begin
               if (i_last && j_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RUN;
                  k_in     = '0;
                  if (j_last) begin
                     j_in = '0;
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |->
         (({1'b0, i_ff} < nr) && ({1'b0, j_ff} < nc) && ({1'b0, k_ff} < nk)))
      else $error("element walk left the configured matrix sizes");

   a_xfer_only_waiting: assert property (@(posedge clock) disable iff (reset)
      xfer |-> (state_ff == ST_WAIT))
      else $error("result handed over while the sequencer was not waiting for it");

endmodule

`default_nettype wire

// ===== hdl/mme_mac.sv =====
`default_nettype none

module mme_mac #(
   parameter int IDX_W      = 3,
   parameter int ELEM_WIDTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire mme_pkg::mac_ctrl_type              issue,
   input  wire logic signed [ELEM_WIDTH-1:0]       a_rdata,
   input  wire logic signed [ELEM_WIDTH-1:0]       b_rdata,
   input  wire logic [IDX_W-1:0]                   el_row,
   input  wire logic [IDX_W-1:0]                   el_col,
   input  wire logic                               el_last,
   input  wire logic                               rsp_tready,
   output logic                                    rsp_tvalid,
   output logic [IDX_W-1:0]                        rsp_row,
   output logic [IDX_W-1:0]                        rsp_col,
   output logic signed [2*ELEM_WIDTH+IDX_W-1:0]    rsp_sum,
   output logic                                    rsp_last,
   output logic                                    xfer
);

   localparam int PROD_W = 2 * ELEM_WIDTH;
   localparam int SUM_W  = PROD_W + IDX_W;

   mme_pkg::mac_ctrl_type     s1_ff, s2_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [SUM_W-1:0]   acc_ff, acc_in;
   logic signed [SUM_W-1:0]   prod_ext, acc_base;
   logic                      done_ff, done_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]          rsp_row_ff, rsp_row_in;
   logic [IDX_W-1:0]          rsp_col_ff, rsp_col_in;
   logic signed [SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Stage one: store data is valid, form the full-width product.
   assign prod_in = PROD_W'(a_rdata) * PROD_W'(b_rdata);

   // Stage two: accumulate, restarting on the first term of each element.
   assign prod_ext = {{IDX_W{prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_base = s2_ff.first ? '0 : acc_ff;
   assign acc_in   = s2_ff.valid ? acc_base + prod_ext : acc_ff;

   assign xfer    = done_ff && (!rsp_valid_ff || rsp_tready);
   assign done_in = (s2_ff.valid && s2_ff.last) ? 1'b1 : (xfer ? 1'b0 : done_ff);

   assign rsp_valid_in = xfer ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_row_in   = xfer ? el_row  : rsp_row_ff;
   assign rsp_col_in   = xfer ? el_col  : rsp_col_ff;
   assign rsp_sum_in   = xfer ? acc_ff  : rsp_sum_ff;
   assign rsp_last_in  = xfer ? el_last : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         s2_ff        <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff        <= issue;
         s2_ff        <= s1_ff;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_col    = rsp_col_ff;
   assign rsp_sum    = rsp_sum_ff;
   assign rsp_last   = rsp_last_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(s2_ff.valid && done_ff))
      else $error("next element entered the accumulator before the previous sum left");

   a_xfer_fills_output: assert property (@(posedge clock) disable iff (reset)
      xfer |=> rsp_valid_ff)
      else $error("finished sum did not reach the output register");

endmodule

`default_nettype wire

// ===== hdl/matrix_multiply_engine_top.sv =====
`default_nettype none

// Load beats (A or B element) are taken while the sequencer is idle and write the store directly.
// A compute beat walks C in row-major order; each element issues one store read per term,
// which then passes the read, multiply and accumulate registers, and a stalled result
// beat holds the walk until the output register frees up. Reset clears the control
// state and sets all three size registers to 8; the element stores are not cleared.
module matrix_multiply_engine_top #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // From bit 0 up: row_index, col_index, elem_value, zero padding.
   input  wire logic [((2*((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1) + ELEM_WIDTH + 7) / 8) * 8 - 1:0]
                                                       req_tdata,
   // op only.
   input  wire logic [mme_pkg::OP_W-1:0]               req_tuser,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // From bit 0 up: out_row, out_col, dot_sum, zero padding.
   output logic [((3*((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1) + 2*ELEM_WIDTH + 7) / 8) * 8 - 1:0]
                                                       rsp_tdata,
   output logic                                        rsp_tlast,
   input  wire logic                                   csr_we,
   input  wire logic [mme_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [mme_pkg::CFG_W-1:0]              csr_data
);

   // Row and column indexes are wide enough to address MAX_DIM entries, and the
   // clamped sizes carry one more bit so that MAX_DIM itself fits.
   localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_W   = IDX_W + 1;
   localparam int SUM_W   = 2 * ELEM_WIDTH + IDX_W;
   localparam int AW      = 2 * IDX_W;
   localparam int DEPTH   = 1 << AW;
   localparam int REQ_W   = 2 * IDX_W + ELEM_WIDTH;
   localparam int RSP_W   = 2 * IDX_W + SUM_W;
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;

   // The size registers keep the bits exactly as written.
   logic [mme_pkg::CFG_W-1:0] rows_ff, rows_in;
   logic [mme_pkg::CFG_W-1:0] inner_ff, inner_in;
   logic [mme_pkg::CFG_W-1:0] cols_ff, cols_in;

   // Sizes as the engine uses them: zero reads as one, anything above MAX_DIM as MAX_DIM.
   function automatic logic [DIM_W-1:0] dim_clamp(input logic [mme_pkg::CFG_W-1:0] raw);
      logic [31:0] wide;
      wide = 32'(raw);
      if (wide == 32'd0) begin
         return DIM_W'(1);
      end else if (wide > 32'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM);
      end else begin
         return DIM_W'(wide);
      end
   endfunction

   logic [DIM_W-1:0] nr, nk, nc;

   always_comb begin
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            mme_pkg::CSR_ROWS_OF_A:  rows_in  = csr_data;
            mme_pkg::CSR_INNER_SIZE: inner_in = csr_data;
            mme_pkg::CSR_COLS_OF_B:  cols_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= mme_pkg::CFG_RESET;
         inner_ff <= mme_pkg::CFG_RESET;
         cols_ff  <= mme_pkg::CFG_RESET;
      end else begin
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
      end
   end

   assign nr = dim_clamp(rows_ff);
   assign nk = dim_clamp(inner_ff);
   assign nc = dim_clamp(cols_ff);

   // Unpack the request beat.
   logic [REQ_W-1:0]      req_fields;
   logic [IDX_W-1:0]      req_row, req_col;
   logic [ELEM_WIDTH-1:0] req_elem;

   assign req_fields = req_tdata[REQ_W-1:0];
   assign req_row    = req_fields[IDX_W-1:0];
   assign req_col    = req_fields[2*IDX_W-1:IDX_W];
   assign req_elem   = req_fields[REQ_W-1:2*IDX_W];

   // Sequencer: decodes beats, writes loads into the stores and walks i, j, k.
   logic                  a_we, b_we;
   logic [AW-1:0]         wr_addr, a_raddr, b_raddr;
   logic [ELEM_WIDTH-1:0] wr_data, a_rdata, b_rdata;
   mme_pkg::mac_ctrl_type issue;
   logic [IDX_W-1:0]      el_row, el_col;
   logic                  el_last, xfer;

   mme_seq #(
      .IDX_W      (IDX_W),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .nr         (nr),
      .nk         (nk),
      .nc         (nc),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_elem   (req_elem),
      .a_we       (a_we),
      .b_we       (b_we),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .a_raddr    (a_raddr),
      .b_raddr    (b_raddr),
      .issue      (issue),
      .el_row     (el_row),
      .el_col     (el_col),
      .el_last    (el_last),
      .xfer       (xfer)
   );

   // The two element stores, addressed as {row, col}. A is read along a row, B down a column.
   mme_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_a_store (
      .clock (clock),
      .we    (a_we),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (issue.valid),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   mme_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_b_store (
      .clock (clock),
      .we    (b_we),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (issue.valid),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   // Multiply-accumulate pipeline and the output register. The output register lets
   // the sequencer return to idle and take new load beats while the final result beat
   // is still waiting on the consumer.
   logic [IDX_W-1:0]        rsp_row, rsp_col;
   logic signed [SUM_W-1:0] rsp_sum;

   mme_mac #(
      .IDX_W      (IDX_W),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .a_rdata    (a_rdata),
      .b_rdata    (b_rdata),
      .el_row     (el_row),
      .el_col     (el_col),
      .el_last    (el_last),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_row    (rsp_row),
      .rsp_col    (rsp_col),
      .rsp_sum    (rsp_sum),
      .rsp_last   (rsp_tlast),
      .xfer       (xfer)
   );

   assign rsp_tdata = RSP_TDATA_W'({rsp_sum, rsp_col, rsp_row});

endmodule

`default_nettype wire
